@@ hw/rtl/poc_pkg.sv @@
// shared widths, constant tables, engine types and control codes for the orientation block
package poc_pkg;

	// field widths of the pixel and result requests
	localparam int PIX_W = 8;
	localparam int OFF_W = 5;
	localparam int ANG_W = 16;
	localparam int MOM_W = 21;

	// patch geometry and angle format
	localparam int HALF_PATCH      = 15;
	localparam int ANGLE_FRAC_BITS = 13;
	localparam int HW_N            = HALF_PATCH + 1;
	localparam int HW_W            = $clog2(HALF_PATCH + 1);
	localparam int HW_IDX_W        = $clog2(HW_N);

	// cordic sizing: angles carry 56 fraction bits, vector normalised into [2^57, 2^58)
	localparam int ZF        = 56;
	localparam int CORDIC_N  = 56;
	localparam int ATAN_W    = 56;
	localparam int ITER_W    = $clog2(CORDIC_N);
	localparam int CW        = 62;
	localparam int ZW        = 60;
	localparam int NORM_BIT  = ZF + 1;
	localparam int COARSE_SH = 8;
	localparam int COARSE_LIM = NORM_BIT - COARSE_SH;
	localparam int ROUND_SH  = ZF - ANGLE_FRAC_BITS;

	typedef logic [HW_W-1:0]   hw_tab_t   [HW_N];
	typedef logic [ATAN_W-1:0] atan_tab_t [CORDIC_N];

	// how the series term shrinks from one step to the next
	typedef enum logic [1:0] {
		SER_DIV25,
		SER_DIV57121,
		SER_SHIFT
	} ser_mode_t;

	// engine sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_ITER,
		ST_FOLD,
		ST_ROUND,
		ST_EMIT
	} eng_state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic              load;
		logic              norm;
		logic              step;
		logic              fold;
		logic              rounding;
		logic              emit;
		logic [ITER_W-1:0] iter;
	} eng_cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic special;
		logic norm_done;
		logic out_free;
	} eng_sts_t;

	// p divided by the odd number 2k+1
	function automatic logic [63:0] odd_div(input logic [63:0] p, input logic [4:0] k);
		logic [63:0] t;
		unique case (k)
			5'd0:  t = p / 64'd1;
			5'd1:  t = p / 64'd3;
			5'd2:  t = p / 64'd5;
			5'd3:  t = p / 64'd7;
			5'd4:  t = p / 64'd9;
			5'd5:  t = p / 64'd11;
			5'd6:  t = p / 64'd13;
			5'd7:  t = p / 64'd15;
			5'd8:  t = p / 64'd17;
			5'd9:  t = p / 64'd19;
			5'd10: t = p / 64'd21;
			5'd11: t = p / 64'd23;
			5'd12: t = p / 64'd25;
			5'd13: t = p / 64'd27;
			5'd14: t = p / 64'd29;
			5'd15: t = p / 64'd31;
			5'd16: t = p / 64'd33;
			5'd17: t = p / 64'd35;
			5'd18: t = p / 64'd37;
			5'd19: t = p / 64'd39;
			5'd20: t = p / 64'd41;
			5'd21: t = p / 64'd43;
			5'd22: t = p / 64'd45;
			5'd23: t = p / 64'd47;
			5'd24: t = p / 64'd49;
			5'd25: t = p / 64'd51;
			5'd26: t = p / 64'd53;
			5'd27: t = p / 64'd55;
			5'd28: t = p / 64'd57;
			5'd29: t = p / 64'd59;
			5'd30: t = p / 64'd61;
			5'd31: t = p / 64'd63;
		endcase
		return t;
	endfunction

	// arctangent power series at 2^-62, truncating each term
	function automatic logic [63:0] atan_series(input logic [63:0] first, input ser_mode_t mode,
			input int sh);
		logic [63:0] sum;
		logic [63:0] p;
		logic [63:0] t;
		sum = '0;
		p   = first;
		for (int k = 0; k < 32; k++) begin
			t = odd_div(p, 5'(k));
			if ((k & 1) == 0) sum = sum + t;
			else sum = sum - t;
			unique case (mode)
				SER_DIV25:    p = p / 64'd25;
				SER_DIV57121: p = p / 64'd57121;
				SER_SHIFT:    p = (sh < 64) ? (p >> sh) : '0;
			endcase
		end
		return sum;
	endfunction

	// atan(2^-i) at 2^-56, rounded from the 2^-62 series
	function automatic atan_tab_t build_atan();
		atan_tab_t   tab;
		logic [63:0] one;
		logic [63:0] q;
		one = 64'h4000_0000_0000_0000;
		q = (64'd4 * atan_series(one / 64'd5, SER_DIV25, 0))
			- atan_series(one / 64'd239, SER_DIV57121, 0);
		tab[0] = ATAN_W'((q + 64'd32) >> 6);
		for (int i = 1; i < CORDIC_N; i++) begin
			q = atan_series(one >> i, SER_SHIFT, 2 * i);
			tab[i] = ATAN_W'((q + 64'd32) >> 6);
		end
		return tab;
	endfunction

	// rounded circle half-widths, upper rows mirrored from the column runs
	function automatic hw_tab_t build_half_width();
		hw_tab_t t;
		int      hp2;
		int      k;
		int      vmax;
		int      vmin;
		int      v0;
		int      n;
		int      r;
		logic    stop;
		hp2 = HALF_PATCH * HALF_PATCH;
		k = 0;
		for (int j = 0; j <= HALF_PATCH; j++)
			if (2 * (j + 1) * (j + 1) <= hp2) k = j + 1;
		vmax = k + 1;
		vmin = (2 * k * k == hp2) ? k : k + 1;
		for (int v = 0; v < HW_N; v++) begin
			t[v] = '0;
			if (v <= vmax) begin
				n = hp2 - v * v;
				r = 0;
				for (int j = 0; j <= HALF_PATCH; j++)
					if ((j + 1) * (j + 1) <= n) r = j + 1;
				if (n > r * r + r) r = r + 1;
				t[v] = HW_W'(r);
			end
		end
		v0 = 0;
		for (int v = HALF_PATCH; v >= 0; v--) begin
			if (v >= vmin) begin
				stop = 1'b0;
				for (int j = 0; j < HW_N; j++) begin
					if (!stop) begin
						if (v0 + 1 < HW_N && t[v0] == t[v0 + 1]) v0 = v0 + 1;
						else stop = 1'b1;
					end
				end
				t[v] = HW_W'(v0);
				v0 = v0 + 1;
			end
		end
		return t;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();
	localparam hw_tab_t   HW_TAB   = build_half_width();

	localparam logic [ZW-1:0] PI_HALF    = ZW'(ATAN_TAB[0]) << 1;
	localparam logic [ZW-1:0] PI_FULL    = ZW'(ATAN_TAB[0]) << 2;
	localparam logic [ZW-1:0] ROUND_HALF = ZW'(1) << (ROUND_SH - 1);

endpackage

@@ hw/rtl/poc_pix_if.sv @@
// pixel request channel: grey value, offsets from the centre and end-of-patch flag
interface poc_pix_if;
	import poc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [PIX_W-1:0]        pixel;
	logic signed [OFF_W-1:0] col_offset;
	logic signed [OFF_W-1:0] row_offset;
	logic                    last;

	modport source (output valid, output pixel, output col_offset, output row_offset,
		output last, input ready);
	modport sink (input valid, input pixel, input col_offset, input row_offset,
		input last, output ready);
endinterface

@@ hw/rtl/poc_ori_if.sv @@
// result request channel: orientation angle and both moments of one patch
interface poc_ori_if;
	import poc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ANG_W-1:0] angle;
	logic signed [MOM_W-1:0] moment_x;
	logic signed [MOM_W-1:0] moment_y;

	modport source (output valid, output angle, output moment_x, output moment_y,
		input ready);
	modport sink (input valid, input angle, input moment_x, input moment_y,
		output ready);
endinterface

@@ hw/rtl/poc_ctrl.sv @@
// sequencer for the angle engine: normalise, rotate, fold, round and hand over
module poc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  poc_pkg::eng_sts_t sts,
	output poc_pkg::eng_cmd_t cmd,
	output logic              busy
);
	import poc_pkg::*;

	eng_state_t        state_q;
	eng_state_t        state_d;
	logic [ITER_W-1:0] iter_q;
	logic [ITER_W-1:0] iter_d;

	// state and rotation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		iter_d   = iter_q;
		cmd      = '0;
		cmd.iter = iter_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_NORM;
				end
			end
			ST_NORM: begin
				if (sts.special) begin
					state_d = ST_FOLD;
				end else if (sts.norm_done) begin
					state_d = ST_ITER;
					iter_d  = '0;
				end else begin
					cmd.norm = 1'b1;
				end
			end
			ST_ITER: begin
				cmd.step = 1'b1;
				if (iter_q == ITER_W'(CORDIC_N - 1)) begin
					state_d = ST_FOLD;
				end else begin
					iter_d = iter_q + ITER_W'(1);
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.rounding = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// a new patch end only reaches an idle engine
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("patch end taken while engine busy");

	// the last rotation leads to the fold
	a_iter_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER && iter_q == ITER_W'(CORDIC_N - 1)) |=> state_q == ST_FOLD)
		else $error("rotation count overran");

	// a handed-over result frees the engine
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && sts.out_free) |=> state_q == ST_IDLE)
		else $error("engine did not return to idle after hand-over");

endmodule

@@ hw/rtl/poc_datapath.sv @@
// moment accumulators, circular mask, cordic vectoring engine and result register
module poc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [poc_pkg::PIX_W-1:0]        pixel,
	input  logic signed [poc_pkg::OFF_W-1:0] col_offset,
	input  logic signed [poc_pkg::OFF_W-1:0] row_offset,
	input  logic                             fire,
	input  poc_pkg::eng_cmd_t                cmd,
	output poc_pkg::eng_sts_t                sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [poc_pkg::ANG_W-1:0] angle,
	output logic signed [poc_pkg::MOM_W-1:0] moment_x,
	output logic signed [poc_pkg::MOM_W-1:0] moment_y
);
	import poc_pkg::*;

	logic [OFF_W-1:0]          abs_row;
	logic [OFF_W-1:0]          abs_col;
	logic [HW_W-1:0]           half_w;
	logic                      keep;
	logic signed [OFF_W+PIX_W:0] prod_x;
	logic signed [OFF_W+PIX_W:0] prod_y;
	logic signed [MOM_W-1:0]   sum_x_q;
	logic signed [MOM_W-1:0]   sum_y_q;
	logic signed [MOM_W-1:0]   sum_x_nx;
	logic signed [MOM_W-1:0]   sum_y_nx;
	logic [MOM_W-1:0]          mag_x;
	logic [MOM_W-1:0]          mag_y;
	logic signed [MOM_W-1:0]   mom_x_q;
	logic signed [MOM_W-1:0]   mom_y_q;
	logic signed [CW-1:0]      cx_q;
	logic signed [CW-1:0]      cy_q;
	logic signed [ZW-1:0]      z_q;
	logic signed [CW-1:0]      xs;
	logic signed [CW-1:0]      ys;
	logic signed [ZW-1:0]      atan_z;
	logic [CW-1:0]             or_v;
	logic                      coarse;
	logic                      x_zero;
	logic                      y_zero;
	logic [ZW-1:0]             z_clamp;
	logic [ZW-1:0]             fold_z;
	logic [ZW-1:0]             round_z;
	logic                      out_valid_q;
	logic signed [ANG_W-1:0]   angle_q;
	logic signed [MOM_W-1:0]   out_x_q;
	logic signed [MOM_W-1:0]   out_y_q;

	// circular mask: row within the patch, column within its half-width
	always_comb begin
		abs_row = row_offset[OFF_W-1] ? OFF_W'(-row_offset) : row_offset;
		abs_col = col_offset[OFF_W-1] ? OFF_W'(-col_offset) : col_offset;
		half_w  = HW_TAB[abs_row[HW_IDX_W-1:0]];
		keep    = (abs_row <= OFF_W'(HALF_PATCH)) && (abs_col <= OFF_W'(half_w));
	end

	// weighted offsets and the running moments with this pixel folded in
	assign prod_x   = col_offset * $signed({1'b0, pixel});
	assign prod_y   = row_offset * $signed({1'b0, pixel});
	assign sum_x_nx = keep ? sum_x_q + MOM_W'(prod_x) : sum_x_q;
	assign sum_y_nx = keep ? sum_y_q + MOM_W'(prod_y) : sum_y_q;

	// accumulators, cleared once a patch is handed to the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (cmd.load) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (fire) begin
			sum_x_q <= sum_x_nx;
			sum_y_q <= sum_y_nx;
		end
	end

	// magnitudes of the final moments
	assign mag_x = sum_x_nx[MOM_W-1] ? MOM_W'(-sum_x_nx) : sum_x_nx;
	assign mag_y = sum_y_nx[MOM_W-1] ? MOM_W'(-sum_y_nx) : sum_y_nx;

	// normalising shift: eight bits while far below the target, then one
	assign or_v   = cx_q | cy_q;
	assign coarse = ~|or_v[CW-1:COARSE_LIM];

	// one rotation of the vectoring cordic
	always_comb begin
		xs     = cx_q >>> cmd.iter;
		ys     = cy_q >>> cmd.iter;
		atan_z = ZW'(ATAN_TAB[cmd.iter]);
	end

	// quadrant fold, axis cases and clamp to the first quadrant
	assign x_zero  = (mom_x_q == '0);
	assign y_zero  = (mom_y_q == '0);
	assign z_clamp = z_q[ZW-1] ? '0 : (($unsigned(z_q) > PI_HALF) ? PI_HALF : $unsigned(z_q));
	always_comb begin
		priority if (x_zero && y_zero) begin
			fold_z = '0;
		end else if (y_zero) begin
			fold_z = mom_x_q[MOM_W-1] ? PI_FULL : '0;
		end else if (x_zero) begin
			fold_z = PI_HALF;
		end else begin
			fold_z = mom_x_q[MOM_W-1] ? PI_FULL - z_clamp : z_clamp;
		end
	end

	// magnitude rounded to the output fraction
	assign round_z = ($unsigned(z_q) + ROUND_HALF) >> ROUND_SH;

	// latched moments of the patch in flight
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mom_x_q <= sum_x_nx;
			mom_y_q <= sum_y_nx;
		end
	end

	// engine vector and angle registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= CW'(mag_x);
			cy_q <= CW'(mag_y);
			z_q  <= '0;
		end else if (cmd.norm) begin
			if (coarse) begin
				cx_q <= cx_q <<< COARSE_SH;
				cy_q <= cy_q <<< COARSE_SH;
			end else begin
				cx_q <= cx_q <<< 1;
				cy_q <= cy_q <<< 1;
			end
		end else if (cmd.step) begin
			if (!cy_q[CW-1] && (cy_q != '0)) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				z_q  <= z_q + atan_z;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				z_q  <= z_q - atan_z;
			end
		end else if (cmd.fold) begin
			z_q <= fold_z;
		end else if (cmd.rounding) begin
			z_q <= round_z;
		end
	end

	// result register, parts the engine from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			angle_q <= mom_y_q[MOM_W-1] ? -z_q[ANG_W-1:0] : z_q[ANG_W-1:0];
			out_x_q <= mom_x_q;
			out_y_q <= mom_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign moment_x  = out_x_q;
	assign moment_y  = out_y_q;

	// status to the sequencer
	assign sts.special   = x_zero || y_zero;
	assign sts.norm_done = |or_v[CW-1:NORM_BIT];
	assign sts.out_free  = !out_valid_q || out_ready;

	// hand-over leaves the moments cleared for the next patch
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (sum_x_q == '0 && sum_y_q == '0))
		else $error("moments not cleared after patch end");

	// rotations only start on a normalised vector
	a_step_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && cmd.iter == '0) |-> sts.norm_done)
		else $error("cordic started on an unnormalised vector");

	// an emitted result shows on the output next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted result not presented");

endmodule

@@ hw/rtl/patch_orientation_centroid_top.sv @@
// Pixels are taken one per cycle but for a patch end held by a busy engine; in-mask pixels add
// into the moments in the cycle they are taken. On the patch end the angle engine runs its
// normalising shifts, 56 cordic rotations, fold and round, then presents the result; with a
// zero moment it goes straight to fold and round. The engine works on one patch at a time;
// a patch end that arrives while it runs waits until it is idle, longer under output stall.
// arst_n clears the moments, the sequencer and the result valid; tables are constants.
module patch_orientation_centroid_top (
	input logic      clk,
	input logic      arst_n,
	poc_pix_if.sink  pixels,
	poc_ori_if.source orient
);
	import poc_pkg::*;

	eng_cmd_t cmd;
	eng_sts_t sts;
	logic     busy;
	logic     fire;
	logic     start;

	// hold only a patch end while the engine is occupied
	assign pixels.ready = ~(busy & pixels.last);
	assign fire         = pixels.valid & pixels.ready;
	assign start        = fire & pixels.last;

	poc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	poc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixels.pixel),
		.col_offset (pixels.col_offset),
		.row_offset (pixels.row_offset),
		.fire       (fire),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (orient.valid),
		.out_ready  (orient.ready),
		.angle      (orient.angle),
		.moment_x   (orient.moment_x),
		.moment_y   (orient.moment_y)
	);

endmodule
